// File: sv/lbef_pkg.sv
// Shared types, constants and the CORDIC angle table of the lidar box exclusion filter.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package lbef_pkg;

	localparam int MAX_SAMPLES      = 4096;
	localparam int TRIG_STAGES      = 16;
	localparam int CORDIC_TABLE_LEN = 24;
	localparam int CELL_COUNT       = (TRIG_STAGES > CORDIC_TABLE_LEN) ? CORDIC_TABLE_LEN
	                                                                  : TRIG_STAGES;
	localparam int STAGE_W          = $clog2(CORDIC_TABLE_LEN);
	localparam int ACC_W            = 34;
	localparam int ADDR_W           = 5;
	localparam int DATA_W           = 32;

	localparam logic signed [ACC_W-1:0] CORDIC_GAIN = ACC_W'(652032874);

	typedef enum logic [2:0] {
		REG_RANGE_LOW,
		REG_RANGE_HIGH,
		REG_ANGLE_START,
		REG_ANGLE_STEP,
		REG_BOX_X_LOW,
		REG_BOX_X_HIGH,
		REG_BOX_Y_LOW,
		REG_BOX_Y_HIGH
	} reg_index_t;

	typedef struct packed {
		logic        [15:0] range_low_mm;
		logic        [15:0] range_high_mm;
		logic signed [15:0] angle_start;
		logic signed [15:0] angle_step;
		logic signed [15:0] box_x_low;
		logic signed [15:0] box_x_high;
		logic signed [15:0] box_y_low;
		logic signed [15:0] box_y_high;
	} cfg_t;

	typedef struct packed {
		logic [15:0] range_mm;
		logic        finite;
		logic        test;
		logic        flip;
	} side_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] x;
		logic signed [ACC_W-1:0] y;
		logic signed [ACC_W-1:0] z;
		side_t                   side;
	} cordic_t;

	function automatic logic signed [ACC_W-1:0] atan_turn(input logic [STAGE_W-1:0] stage);
		logic signed [ACC_W-1:0] val;
		case (stage)
			5'd0:    val = ACC_W'(536870912);
			5'd1:    val = ACC_W'(316933406);
			5'd2:    val = ACC_W'(167458907);
			5'd3:    val = ACC_W'(85004756);
			5'd4:    val = ACC_W'(42667331);
			5'd5:    val = ACC_W'(21354465);
			5'd6:    val = ACC_W'(10679838);
			5'd7:    val = ACC_W'(5340245);
			5'd8:    val = ACC_W'(2670163);
			5'd9:    val = ACC_W'(1335087);
			5'd10:   val = ACC_W'(667544);
			5'd11:   val = ACC_W'(333772);
			5'd12:   val = ACC_W'(166886);
			5'd13:   val = ACC_W'(83443);
			5'd14:   val = ACC_W'(41722);
			5'd15:   val = ACC_W'(20861);
			5'd16:   val = ACC_W'(10430);
			5'd17:   val = ACC_W'(5215);
			5'd18:   val = ACC_W'(2608);
			5'd19:   val = ACC_W'(1304);
			5'd20:   val = ACC_W'(652);
			5'd21:   val = ACC_W'(326);
			5'd22:   val = ACC_W'(163);
			5'd23:   val = ACC_W'(81);
			default: val = '0;
		endcase
		return val;
	endfunction

endpackage

`default_nettype wire

// File: sv/lbef_front.sv
// Input stage: range window test, beam angle and CORDIC start vector.
// Depends on lbef_pkg.
`default_nettype none

module lbef_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lbef_pkg::cfg_t       cfg,
	input  logic                 up_valid,
	output logic                 up_stall,
	input  logic [15:0]          range_mm,
	input  logic                 range_finite,
	input  logic [11:0]          sample_index,
	output logic                 down_valid,
	input  logic                 down_stall,
	output lbef_pkg::cordic_t    down_data
);
	import lbef_pkg::*;

	logic        valid_s1;
	cordic_t     data_s1;
	cordic_t     next_c;
	logic [27:0] prod_c;
	logic [15:0] angle_c;
	logic        flip_c;
	logic        window_c;

	assign prod_c   = 28'(sample_index) * {12'd0, cfg.angle_step};
	assign angle_c  = cfg.angle_start + prod_c[15:0];
	assign flip_c   = angle_c[15] ^ angle_c[14];
	assign window_c = (range_mm >= cfg.range_low_mm) && (range_mm <= cfg.range_high_mm)
		&& (32'(sample_index) < 32'(MAX_SAMPLES));

	always_comb begin
		next_c.x             = CORDIC_GAIN;
		next_c.y             = '0;
		next_c.z             = ACC_W'($signed({angle_c[15] ^ flip_c, angle_c[14:0], 16'd0}));
		next_c.side.range_mm = range_mm;
		next_c.side.finite   = range_finite;
		next_c.side.test     = range_finite && window_c;
		next_c.side.flip     = flip_c;
	end

	assign up_stall = valid_s1 && down_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!up_stall) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!up_stall && up_valid) begin
			data_s1 <= next_c;
		end
	end

	assign down_valid = valid_s1;
	assign down_data  = data_s1;

endmodule

`default_nettype wire

// File: sv/lbef_cordic_cell.sv
// One rotation-mode CORDIC iteration with its own pipeline register.
// Depends on lbef_pkg.
`default_nettype none

module lbef_cordic_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [lbef_pkg::STAGE_W-1:0]  stage,
	input  logic                          up_valid,
	output logic                          up_stall,
	input  lbef_pkg::cordic_t             up_data,
	output logic                          down_valid,
	input  logic                          down_stall,
	output lbef_pkg::cordic_t             down_data
);
	import lbef_pkg::*;

	logic                    valid_s1;
	cordic_t                 data_s1;
	cordic_t                 next_c;
	logic signed [ACC_W-1:0] dx_c;
	logic signed [ACC_W-1:0] dy_c;
	logic signed [ACC_W-1:0] turn_c;

	always_comb begin
		dx_c   = $signed(up_data.y) >>> stage;
		dy_c   = $signed(up_data.x) >>> stage;
		turn_c = atan_turn(stage);
		next_c = up_data;
		if (!up_data.z[ACC_W-1]) begin
			next_c.x = up_data.x - dx_c;
			next_c.y = up_data.y + dy_c;
			next_c.z = up_data.z - turn_c;
		end else begin
			next_c.x = up_data.x + dx_c;
			next_c.y = up_data.y - dy_c;
			next_c.z = up_data.z + turn_c;
		end
	end

	assign up_stall = valid_s1 && down_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!up_stall) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!up_stall && up_valid) begin
			data_s1 <= next_c;
		end
	end

	assign down_valid = valid_s1;
	assign down_data  = data_s1;

endmodule

`default_nettype wire

// File: sv/lbef_tail.sv
// Back end: Q1.15 rounding, point projection, box test and the output register.
// Depends on lbef_pkg.
`default_nettype none

module lbef_tail (
	input  logic              clk,
	input  logic              arst_n,
	input  lbef_pkg::cfg_t    cfg,
	input  logic              up_valid,
	output logic              up_stall,
	input  lbef_pkg::cordic_t up_data,
	output logic              down_valid,
	input  logic              down_stall,
	output logic [15:0]       range_out_mm,
	output logic              is_nan,
	output logic              dropped
);
	import lbef_pkg::*;

	function automatic logic signed [15:0] to_q15(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		logic signed [15:0]      q;
		r = (v + $signed(ACC_W'(16384))) >>> 15;
		if (r > $signed(ACC_W'(32767))) begin
			q = 16'sh7fff;
		end else if (r < -$signed(ACC_W'(32768))) begin
			q = 16'sh8000;
		end else begin
			q = r[15:0];
		end
		return q;
	endfunction

	logic                    valid_s1;
	logic                    valid_s2;
	logic                    valid_s3;
	logic                    stall_s1;
	logic                    stall_s2;
	logic                    stall_s3;
	side_t                   side_s1;
	side_t                   side_s2;
	logic signed [15:0]      cos_s1;
	logic signed [15:0]      sin_s1;
	logic signed [32:0]      px_s2;
	logic signed [32:0]      py_s2;
	logic [15:0]             range_s3;
	logic                    nan_s3;
	logic                    drop_s3;
	logic signed [ACC_W-1:0] xf_c;
	logic signed [ACC_W-1:0] yf_c;
	logic signed [ACC_W-1:0] px_c;
	logic signed [ACC_W-1:0] py_c;
	logic                    drop_c;

	assign stall_s3 = valid_s3 && down_stall;
	assign stall_s2 = valid_s2 && stall_s3;
	assign stall_s1 = valid_s1 && stall_s2;
	assign up_stall = stall_s1;

	assign xf_c = up_data.side.flip ? -up_data.x : up_data.x;
	assign yf_c = up_data.side.flip ? -up_data.y : up_data.y;

	assign px_c = (ACC_W'(px_s2) + $signed(ACC_W'(16384))) >>> 15;
	assign py_c = (ACC_W'(py_s2) + $signed(ACC_W'(16384))) >>> 15;

	assign drop_c = side_s2.test
		&& (px_c >= ACC_W'(cfg.box_x_low)) && (px_c <= ACC_W'(cfg.box_x_high))
		&& (py_c >= ACC_W'(cfg.box_y_low)) && (py_c <= ACC_W'(cfg.box_y_high));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (!stall_s1) begin
				valid_s1 <= up_valid;
			end
			if (!stall_s2) begin
				valid_s2 <= valid_s1;
			end
			if (!stall_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s1 && up_valid) begin
			side_s1 <= up_data.side;
			cos_s1  <= to_q15(xf_c);
			sin_s1  <= to_q15(yf_c);
		end
		if (!stall_s2 && valid_s1) begin
			side_s2 <= side_s1;
			px_s2   <= $signed({1'b0, side_s1.range_mm}) * cos_s1;
			py_s2   <= $signed({1'b0, side_s1.range_mm}) * sin_s1;
		end
		if (!stall_s3 && valid_s2) begin
			range_s3 <= (drop_c || !side_s2.finite) ? 16'd0 : side_s2.range_mm;
			nan_s3   <= drop_c || !side_s2.finite;
			drop_s3  <= drop_c;
		end
	end

	assign down_valid   = valid_s3;
	assign range_out_mm = range_s3;
	assign is_nan       = nan_s3;
	assign dropped      = drop_s3;

endmodule

`default_nettype wire

// File: sv/lidar_box_exclusion_filter_top.sv
// Top level of the lidar box exclusion filter: register file, input stage,
// chain of CORDIC cells and back end. Depends on lbef_pkg, lbef_front,
// lbef_cordic_cell and lbef_tail.
//
//   channel   handshake                  payload
//   in        in_valid / in_stall        range_mm, range_finite, sample_index
//   out       out_valid / out_stall      range_out_mm, is_nan, dropped
//   config    psel / penable / pready    pwrite, paddr, pwdata, prdata
//
// One sample is accepted per cycle while in_stall is low. Each sample passes
// the input stage register, the register of every CORDIC cell, which performs
// one iteration, and the back-end registers. Reset clears all valid bits and
// loads the register defaults. A stall at the output holds each full stage,
// and a stage keeps taking data as long as the one after it has room.
`default_nettype none

module lidar_box_exclusion_filter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] range_mm,
	input  logic        range_finite,
	input  logic [11:0] sample_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] range_out_mm,
	output logic        is_nan,
	output logic        dropped,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import lbef_pkg::*;

	cfg_t          cfg_q;
	reg_index_t    reg_index;
	logic          cfg_write;
	logic [CELL_COUNT:0] chain_valid;
	logic [CELL_COUNT:0] chain_stall;
	cordic_t       chain_data [CELL_COUNT+1];

	assign pready    = 1'b1;
	assign reg_index = reg_index_t'(paddr[ADDR_W-1:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_low_mm  <= 16'd0;
			cfg_q.range_high_mm <= 16'hffff;
			cfg_q.angle_start   <= 16'sd0;
			cfg_q.angle_step    <= 16'sd0;
			cfg_q.box_x_low     <= -16'sd500;
			cfg_q.box_x_high    <= 16'sd400;
			cfg_q.box_y_low     <= -16'sd600;
			cfg_q.box_y_high    <= 16'sd200;
		end else if (cfg_write) begin
			unique case (reg_index)
				REG_RANGE_LOW:   cfg_q.range_low_mm  <= pwdata[15:0];
				REG_RANGE_HIGH:  cfg_q.range_high_mm <= pwdata[15:0];
				REG_ANGLE_START: cfg_q.angle_start   <= pwdata[15:0];
				REG_ANGLE_STEP:  cfg_q.angle_step    <= pwdata[15:0];
				REG_BOX_X_LOW:   cfg_q.box_x_low     <= pwdata[15:0];
				REG_BOX_X_HIGH:  cfg_q.box_x_high    <= pwdata[15:0];
				REG_BOX_Y_LOW:   cfg_q.box_y_low     <= pwdata[15:0];
				REG_BOX_Y_HIGH:  cfg_q.box_y_high    <= pwdata[15:0];
				default:         cfg_q               <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_index)
			REG_RANGE_LOW:   prdata = {16'd0, cfg_q.range_low_mm};
			REG_RANGE_HIGH:  prdata = {16'd0, cfg_q.range_high_mm};
			REG_ANGLE_START: prdata = DATA_W'(cfg_q.angle_start);
			REG_ANGLE_STEP:  prdata = DATA_W'(cfg_q.angle_step);
			REG_BOX_X_LOW:   prdata = DATA_W'(cfg_q.box_x_low);
			REG_BOX_X_HIGH:  prdata = DATA_W'(cfg_q.box_x_high);
			REG_BOX_Y_LOW:   prdata = DATA_W'(cfg_q.box_y_low);
			REG_BOX_Y_HIGH:  prdata = DATA_W'(cfg_q.box_y_high);
			default:         prdata = '0;
		endcase
	end

	lbef_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.up_valid     (in_valid),
		.up_stall     (in_stall),
		.range_mm     (range_mm),
		.range_finite (range_finite),
		.sample_index (sample_index),
		.down_valid   (chain_valid[0]),
		.down_stall   (chain_stall[0]),
		.down_data    (chain_data[0])
	);

	for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
		lbef_cordic_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.stage      (STAGE_W'(i)),
			.up_valid   (chain_valid[i]),
			.up_stall   (chain_stall[i]),
			.up_data    (chain_data[i]),
			.down_valid (chain_valid[i+1]),
			.down_stall (chain_stall[i+1]),
			.down_data  (chain_data[i+1])
		);
	end

	lbef_tail u_tail (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.up_valid     (chain_valid[CELL_COUNT]),
		.up_stall     (chain_stall[CELL_COUNT]),
		.up_data      (chain_data[CELL_COUNT]),
		.down_valid   (out_valid),
		.down_stall   (out_stall),
		.range_out_mm (range_out_mm),
		.is_nan       (is_nan),
		.dropped      (dropped)
	);

`ifndef SYNTHESIS
	// A dropped sample always leaves as a NaN with a zero range.
	a_drop_is_nan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped |-> is_nan && (range_out_mm == 16'd0))
		else $error("dropped sample not marked NaN with zero range");

	// A non-NaN result always carries a clear drop flag.
	a_pass_not_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_nan |-> !dropped)
		else $error("passed sample carries drop flag");

	// Without back pressure at the output the whole chain keeps taking samples.
	a_no_stall_through: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output is free");
`endif

endmodule

`default_nettype wire
